// ===== sv/isphere_pkg.sv =====
// ----------------------------------------------------------------------------
// Inverted sphere mesh generator package
// Shared constants, CORDIC arctangent table, pipeline record and helpers.
// ----------------------------------------------------------------------------
package isphere_pkg;

  localparam int unsigned SEG_W        = 9;
  localparam int unsigned RAD_W        = 15;
  localparam int unsigned VAL_W        = 18;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned MAX_SEGMENTS = 256;
  localparam int unsigned MIN_WIDTH    = 3;
  localparam int unsigned MIN_HEIGHT   = 2;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned DIV_STEPS    = 32;
  localparam int unsigned UV_STEPS     = 16;

  localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(256);
  localparam logic [SEG_W-1:0] WIDTH_RST  = SEG_W'(32);
  localparam logic [SEG_W-1:0] HEIGHT_RST = SEG_W'(16);

  // Pipeline stage map
  localparam int unsigned ST_DIV     = 1;
  localparam int unsigned ST_ANGLE   = ST_DIV + DIV_STEPS;
  localparam int unsigned ST_CORDIC  = ST_ANGLE + 1;
  localparam int unsigned ST_MAP     = ST_CORDIC + CORDIC_STEPS;
  localparam int unsigned ST_MUL1    = ST_MAP + 1;
  localparam int unsigned ST_MUL2    = ST_MUL1 + 1;
  localparam int unsigned ST_ROUND   = ST_MUL2 + 1;
  localparam int unsigned NUM_STAGES = ST_ROUND + 1;

  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;
  localparam logic [31:0] QUARTER_OFS = 32'h2000_0000;

  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [2:0] {
    KIND_POS = 3'd0,
    KIND_NRM = 3'd1,
    KIND_TAN = 3'd2,
    KIND_UV  = 3'd3,
    KIND_TRI = 3'd4,
    KIND_REJ = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    SLOT_POS   = 3'd0,
    SLOT_NRM   = 3'd1,
    SLOT_TAN   = 3'd2,
    SLOT_UV    = 3'd3,
    SLOT_TRI_A = 3'd4,
    SLOT_TRI_B = 3'd5
  } slot_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [17:0] c;
    logic signed [17:0] s;
  } sc_t;

  // One point in flight; fields are reused as the point moves down the pipe
  typedef struct packed {
    logic [SEG_W-1:0]   col;
    logic [SEG_W-1:0]   row;
    logic               rej;
    logic               has_a;
    logic               has_b;
    // long division
    logic [SEG_W-1:0]   pr;
    logic [31:0]        pq;
    logic [SEG_W-1:0]   tr;
    logic [31:0]        tq;
    logic               ttop;
    logic [SEG_W-1:0]   ur;
    logic [15:0]        ud;
    logic [15:0]        uq;
    logic               utop;
    logic [SEG_W-1:0]   vr;
    logic [15:0]        vd;
    logic [15:0]        vq;
    logic               vtop;
    // cordic
    logic signed [32:0] px;
    logic signed [32:0] py;
    logic signed [31:0] pz;
    logic [1:0]         pquad;
    logic signed [32:0] tx;
    logic signed [32:0] ty;
    logic signed [31:0] tz;
    logic [1:0]         tquad;
    // Q1.15 trig
    logic signed [17:0] cp;
    logic signed [17:0] sp;
    logic signed [17:0] ct;
    logic signed [17:0] st;
    // products
    logic signed [35:0] pcs;
    logic signed [35:0] pss;
    logic signed [33:0] rct;
    logic signed [51:0] rx;
    logic signed [51:0] rz;
    logic [VAL_W-1:0]   idx_a;
    logic [VAL_W-1:0]   idx_b;
    logic [VAL_W-1:0]   idx_c;
    logic [VAL_W-1:0]   idx_d;
    // results
    logic signed [17:0] pos_x;
    logic signed [17:0] pos_y;
    logic signed [17:0] pos_z;
    logic signed [17:0] nrm_x;
    logic signed [17:0] nrm_y;
    logic signed [17:0] nrm_z;
    logic signed [17:0] tan_x;
    logic signed [17:0] tan_z;
  } pipe_t;

  // Clamp to the Q1.15 range
  function automatic logic signed [17:0] sat16(input logic signed [37:0] v);
    logic signed [17:0] r;
    if (v > 38'sd32767) begin
      r = 18'sd32767;
    end else if (v < -38'sd32768) begin
      r = -18'sd32768;
    end else begin
      r = v[17:0];
    end
    return r;
  endfunction

  // Fold the CORDIC vector back to its quadrant and round to Q1.15
  function automatic sc_t sc_round(input logic signed [32:0] x,
                                   input logic signed [32:0] y,
                                   input logic [1:0] quad);
    logic signed [33:0] c;
    logic signed [33:0] s;
    sc_t r;
    unique case (quad)
      2'd0: begin c = 34'(x);  s = 34'(y);  end
      2'd1: begin c = -34'(y); s = 34'(x);  end
      2'd2: begin c = -34'(x); s = -34'(y); end
      default: begin c = 34'(y); s = -34'(x); end
    endcase
    r.c = 18'((c + 34'sd16384) >>> 15);
    r.s = 18'((s + 34'sd16384) >>> 15);
    return r;
  endfunction

endpackage

// ===== sv/inverted_sphere_mesh_generator.sv =====
// ----------------------------------------------------------------------------
// Inverted sphere mesh generator
// Turns one grid point of an inward-facing UV sphere into position, normal,
// tangent, uv and up to two triangles.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one (column, row) request per accepted cycle
//   (in_valid_i high, in_stall_o low). The output channel returns the results
//   of each request in order: position, normal, tangent, uv, then the
//   triangles the point opens; last_o marks the final one. A point outside
//   the grid returns a single rejected result.
//   The configuration port is always ready; write it only while no request
//   is in flight.
//   From request to first result, a request passes one capture stage,
//   32 long-division stages for the angles and uv, one angle split,
//   16 CORDIC stages, one quadrant fold, three multiply/round stages and
//   the result register.
//   Each request yields 4 to 6 results (1 for a rejected point) on the
//   single result channel, which sets the pace; the pipeline takes a
//   request per cycle until that channel backs up.
//   Reset clears all valid bits and loads radius 256, 32 by 16 segments.
//   A stalled output holds its result; the pipe keeps moving while its last
//   stage is empty, then holds with in_stall_o high.
// ----------------------------------------------------------------------------
module inverted_sphere_mesh_generator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [isphere_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [isphere_pkg::RAD_W-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [isphere_pkg::SEG_W-1:0]        column_i,
  input  logic [isphere_pkg::SEG_W-1:0]        row_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [2:0]                           kind_o,
  output logic signed [isphere_pkg::VAL_W-1:0] value_a_o,
  output logic signed [isphere_pkg::VAL_W-1:0] value_b_o,
  output logic signed [isphere_pkg::VAL_W-1:0] value_c_o,
  output logic                                 last_o
);
  import isphere_pkg::*;

  logic [RAD_W-1:0] radius_q;
  logic [SEG_W-1:0] width_q;
  logic [SEG_W-1:0] height_q;
  logic [SEG_W-1:0] cfg_seg;

  logic  v_q [NUM_STAGES];
  pipe_t d_q [NUM_STAGES];
  pipe_t d_d [NUM_STAGES];

  logic  adv;
  logic  ser_v_q;
  pipe_t ser_q;
  slot_e step_q;
  slot_e step_next;
  logic  ser_take;
  logic  ser_last;
  logic  ser_free;

  // Configuration: always ready, clamp segment counts
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_seg = cfg_data_i[SEG_W-1:0];
    if (10'(cfg_seg) > 10'(MAX_SEGMENTS)) begin
      cfg_seg = SEG_W'(MAX_SEGMENTS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_RADIUS: radius_q <= cfg_data_i;
        CFG_WIDTH:  width_q  <= (cfg_seg < SEG_W'(MIN_WIDTH)) ? SEG_W'(MIN_WIDTH) : cfg_seg;
        CFG_HEIGHT: height_q <= (cfg_seg < SEG_W'(MIN_HEIGHT)) ? SEG_W'(MIN_HEIGHT) : cfg_seg;
        default: ;
      endcase
    end
  end

  // Stage logic
  always_comb begin
    pipe_t             p;
    logic [SEG_W:0]    r2;
    logic              qb;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    sc_t               scp;
    sc_t               sct;
    logic signed [15:0] rad;

    rad = signed'({1'b0, radius_q});

    // Capture: reject test, quad flags, division seeds
    p = '0;
    p.col   = column_i;
    p.row   = row_i;
    p.rej   = (column_i > width_q) || (row_i > height_q);
    p.has_a = (column_i < width_q) && (row_i < height_q) && (row_i != '0);
    p.has_b = (column_i < width_q) && (row_i < height_q) &&
              (row_i != SEG_W'(height_q - SEG_W'(1)));
    p.pr    = (column_i >= width_q) ? SEG_W'(column_i - width_q) : column_i;
    p.tr    = (row_i >= height_q) ? SEG_W'(row_i - height_q) : row_i;
    p.ttop  = (row_i >= height_q);
    p.ur    = p.pr;
    p.utop  = (column_i >= width_q);
    p.ud    = 16'(width_q >> 1);
    p.vr    = p.tr;
    p.vtop  = p.ttop;
    p.vd    = 16'(height_q >> 1);
    d_d[0]  = p;

    for (int s = 1; s < NUM_STAGES; s++) begin
      p = d_q[s-1];
      if (s < ST_ANGLE) begin
        // One quotient bit per divider
        r2 = {p.pr, 1'b0};
        qb = (r2 >= {1'b0, width_q});
        p.pr = qb ? SEG_W'(r2 - {1'b0, width_q}) : r2[SEG_W-1:0];
        p.pq = {p.pq[30:0], qb};
        r2 = {p.tr, 1'b0};
        qb = (r2 >= {1'b0, height_q});
        p.tr = qb ? SEG_W'(r2 - {1'b0, height_q}) : r2[SEG_W-1:0];
        p.tq = {p.tq[30:0], qb};
        if (s < ST_DIV + UV_STEPS) begin
          r2 = {p.ur, p.ud[15]};
          qb = (r2 >= {1'b0, width_q});
          p.ur = qb ? SEG_W'(r2 - {1'b0, width_q}) : r2[SEG_W-1:0];
          p.uq = {p.uq[14:0], qb};
          p.ud = {p.ud[14:0], 1'b0};
          r2 = {p.vr, p.vd[15]};
          qb = (r2 >= {1'b0, height_q});
          p.vr = qb ? SEG_W'(r2 - {1'b0, height_q}) : r2[SEG_W-1:0];
          p.vq = {p.vq[14:0], qb};
          p.vd = {p.vd[14:0], 1'b0};
        end
      end else if (s == ST_ANGLE) begin
        // Split each turn into quadrant and offset
        p.pquad = 2'((p.pq + QUARTER_OFS) >> 30);
        p.pz    = signed'({2'b00, 30'(p.pq + QUARTER_OFS)}) - signed'(QUARTER_OFS);
        p.px    = CORDIC_START;
        p.py    = '0;
        p.tquad = 2'(({p.ttop, p.tq[31:1]} + QUARTER_OFS) >> 30);
        p.tz    = signed'({2'b00, 30'({p.ttop, p.tq[31:1]} + QUARTER_OFS)}) -
                  signed'(QUARTER_OFS);
        p.tx    = CORDIC_START;
        p.ty    = '0;
      end else if (s < ST_MAP) begin
        // Rotate both vectors one step
        dx = p.py >>> (s - ST_CORDIC);
        dy = p.px >>> (s - ST_CORDIC);
        if (p.pz >= 0) begin
          p.px = p.px - dx;
          p.py = p.py + dy;
          p.pz = p.pz - signed'(ATAN_TURNS[s - ST_CORDIC]);
        end else begin
          p.px = p.px + dx;
          p.py = p.py - dy;
          p.pz = p.pz + signed'(ATAN_TURNS[s - ST_CORDIC]);
        end
        dx = p.ty >>> (s - ST_CORDIC);
        dy = p.tx >>> (s - ST_CORDIC);
        if (p.tz >= 0) begin
          p.tx = p.tx - dx;
          p.ty = p.ty + dy;
          p.tz = p.tz - signed'(ATAN_TURNS[s - ST_CORDIC]);
        end else begin
          p.tx = p.tx + dx;
          p.ty = p.ty - dy;
          p.tz = p.tz + signed'(ATAN_TURNS[s - ST_CORDIC]);
        end
      end else if (s == ST_MAP) begin
        scp  = sc_round(p.px, p.py, p.pquad);
        sct  = sc_round(p.tx, p.ty, p.tquad);
        p.cp = scp.c;
        p.sp = scp.s;
        p.ct = sct.c;
        p.st = sct.s;
      end else if (s == ST_MUL1) begin
        p.pcs   = p.cp * p.st;
        p.pss   = p.sp * p.st;
        p.rct   = rad * p.ct;
        p.idx_b = VAL_W'(p.row * ({1'b0, width_q} + 10'd1) + 19'(p.col));
      end else if (s == ST_MUL2) begin
        p.rx    = rad * p.pcs;
        p.rz    = rad * p.pss;
        p.pos_y = 18'((p.rct + 34'sd16384) >>> 15);
        p.nrm_x = sat16(38'((38'(p.pcs) + 38'sd16384) >>> 15));
        p.nrm_y = sat16(-38'(p.ct));
        p.nrm_z = sat16(38'((-38'(p.pss) + 38'sd16384) >>> 15));
        p.tan_x = sat16(38'(p.sp));
        p.tan_z = sat16(38'(p.cp));
      end else begin
        p.pos_x = 18'((-53'(p.rx) + 53'sd536870912) >>> 30);
        p.pos_z = 18'((53'(p.rz) + 53'sd536870912) >>> 30);
        p.idx_a = p.idx_b + VAL_W'(1);
        p.idx_c = p.idx_b + VAL_W'(width_q) + VAL_W'(1);
        p.idx_d = p.idx_b + VAL_W'(width_q) + VAL_W'(2);
      end
      d_d[s] = p;
    end
  end

  // Advance the pipe while the result register frees up or the tail is empty
  assign ser_take   = ser_v_q && !out_stall_i;
  assign ser_free   = !ser_v_q || (ser_take && ser_last);
  assign adv        = ser_free || !v_q[NUM_STAGES-1];
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (adv) begin
      v_q[0] <= in_valid_i;
      for (int s = 1; s < NUM_STAGES; s++) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        d_q[s] <= d_d[s];
      end
    end
  end

  // Result sequencer: walk the slots of the held point
  always_comb begin
    ser_last  = 1'b0;
    step_next = step_q;
    unique case (step_q)
      SLOT_POS:   step_next = SLOT_NRM;
      SLOT_NRM:   step_next = SLOT_TAN;
      SLOT_TAN:   step_next = SLOT_UV;
      SLOT_UV:    step_next = ser_q.has_a ? SLOT_TRI_A : SLOT_TRI_B;
      SLOT_TRI_A: step_next = SLOT_TRI_B;
      default:    step_next = SLOT_TRI_B;
    endcase
    priority if (ser_q.rej) begin
      ser_last = 1'b1;
    end else if (step_q == SLOT_UV) begin
      ser_last = !ser_q.has_a && !ser_q.has_b;
    end else if (step_q == SLOT_TRI_A) begin
      ser_last = !ser_q.has_b;
    end else begin
      ser_last = (step_q == SLOT_TRI_B);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q <= 1'b0;
      step_q  <= SLOT_POS;
    end else if (ser_free) begin
      ser_v_q <= v_q[NUM_STAGES-1];
      step_q  <= SLOT_POS;
    end else if (ser_take) begin
      step_q  <= step_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_free) begin
      ser_q <= d_q[NUM_STAGES-1];
    end
  end

  // Drive the result fields from the held point
  assign out_valid_o = ser_v_q;
  assign last_o      = ser_last;

  always_comb begin
    kind_o    = KIND_REJ;
    value_a_o = '0;
    value_b_o = '0;
    value_c_o = '0;
    if (!ser_q.rej) begin
      unique case (step_q)
        SLOT_POS: begin
          kind_o    = KIND_POS;
          value_a_o = ser_q.pos_x;
          value_b_o = ser_q.pos_y;
          value_c_o = ser_q.pos_z;
        end
        SLOT_NRM: begin
          kind_o    = KIND_NRM;
          value_a_o = ser_q.nrm_x;
          value_b_o = ser_q.nrm_y;
          value_c_o = ser_q.nrm_z;
        end
        SLOT_TAN: begin
          kind_o    = KIND_TAN;
          value_a_o = ser_q.tan_x;
          value_c_o = ser_q.tan_z;
        end
        SLOT_UV: begin
          kind_o    = KIND_UV;
          value_a_o = signed'({1'b0, ser_q.utop, ser_q.uq});
          value_b_o = signed'({1'b0, ser_q.vtop, ser_q.vq});
        end
        SLOT_TRI_A: begin
          kind_o    = KIND_TRI;
          value_a_o = signed'(ser_q.idx_b);
          value_b_o = signed'(ser_q.idx_a);
          value_c_o = signed'(ser_q.idx_d);
        end
        SLOT_TRI_B: begin
          kind_o    = KIND_TRI;
          value_a_o = signed'(ser_q.idx_c);
          value_b_o = signed'(ser_q.idx_b);
          value_c_o = signed'(ser_q.idx_d);
        end
        default: begin
          kind_o = KIND_REJ;
        end
      endcase
    end
  end

endmodule
